// ===== sv/wpg_pkg.sv =====
// ----------------------------------------------------------------------------
// wpg_pkg
// Shared types, constants and the arctangent table for waypoint guidance.
// ----------------------------------------------------------------------------
package wpg_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int IterW = $clog2(CORDIC_STEPS + 1);
  localparam logic [31:0] K_Q32 = 32'd2608131496;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_DIST   = 3'd1;
  localparam logic [2:0] REG_TURN   = 3'd2;
  localparam logic [2:0] REG_RADIUS = 3'd3;
  localparam logic [2:0] REG_DEST_X = 3'd4;
  localparam logic [2:0] REG_DEST_Y = 3'd5;

  localparam logic [1:0] MODE_GOTO  = 2'd1;
  localparam logic [1:0] MODE_ORBIT = 2'd2;

  localparam logic CMD_LOAD = 1'b0;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] load_x;
    logic signed [31:0] load_y;
    logic        [15:0] load_heading;
  } wpg_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [15:0] heading;
  } wpg_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_VEC_INIT,
    ST_VEC_ITER,
    ST_TURN,
    ST_ROT_INIT,
    ST_ROT_MUL,
    ST_ROT_ITER,
    ST_FINISH,
    ST_OUT
  } wpg_state_t;

  typedef struct packed {
    logic load;
    logic vec_init;
    logic vec_iter;
    logic turn;
    logic rot_init;
    logic rot_mul;
    logic rot_iter;
    logic finish;
  } wpg_cmd_t;

  typedef struct packed {
    logic iter_last;
    logic at_dest;
  } wpg_status_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/waypoint_guidance_step.sv =====
// ----------------------------------------------------------------------------
// waypoint_guidance_step
// One time step of turn-rate-limited 2-D waypoint guidance.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_data): a load transaction sets position
// and heading; an advance transaction moves the vehicle one step in the mode
// held in the configuration registers. Each transaction gives one result on
// the output channel (out_valid/out_stall/out_data): position and heading.
// Go-to runs a 16-step CORDIC vectoring pass for the bearing (skipped when
// already on the destination), then a 16-step rotation pass for the move;
// free flight and orbit run the rotation pass only. Both passes share the
// one CORDIC unit, one step a cycle. One transaction is in work at a time:
// a new one is taken only back in idle. Configuration is written through
// cfg_we, cfg_index and cfg_data; the user must write it only while idle,
// as the block itself does not enforce this. Synchronous reset clears state,
// position, heading and configuration registers (orbit radius 256). While
// out_stall is high the result holds and no new transaction is taken.
// ----------------------------------------------------------------------------
module waypoint_guidance_step
  import wpg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  wpg_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output wpg_out_t    out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [1:0]  flight_mode;
  logic [15:0] step_distance;
  logic [14:0] turn_step;
  logic [23:0] orbit_radius;
  logic signed [31:0] dest_x, dest_y;
  wpg_cmd_t    ctl;
  wpg_status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      flight_mode <= '0;
      step_distance <= '0;
      turn_step <= '0;
      orbit_radius <= 24'd256;
      dest_x <= '0;
      dest_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:   flight_mode <= cfg_data[1:0];
        REG_DIST:   step_distance <= cfg_data[15:0];
        REG_TURN:   turn_step <= cfg_data[14:0];
        REG_RADIUS: orbit_radius <= cfg_data[23:0];
        REG_DEST_X: dest_x <= cfg_data;
        REG_DEST_Y: dest_y <= cfg_data;
        default: ;
      endcase
    end
  end

  wpg_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_cmd(in_data.cmd), .mode(flight_mode),
    .out_stall, .status, .in_stall, .out_valid, .ctl
  );

  wpg_dp u_dp (
    .clk, .rst, .in_data, .ctl, .mode(flight_mode), .step_distance,
    .turn_step, .orbit_radius, .dest_x, .dest_y, .status, .out_data
  );

endmodule

// ===== sv/wpg_ctrl.sv =====
// ----------------------------------------------------------------------------
// wpg_ctrl
// Sequencer: walks one transaction through load, bearing, turn and move.
// ----------------------------------------------------------------------------
module wpg_ctrl
  import wpg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_cmd,
  input  logic [1:0]  mode,
  input  logic        out_stall,
  input  wpg_status_t status,
  output logic        in_stall,
  output logic        out_valid,
  output wpg_cmd_t    ctl
);

  wpg_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_LOAD) state_next = ST_LOAD;
          else if (mode == MODE_GOTO) state_next = ST_VEC_INIT;
          else state_next = ST_ROT_INIT;
        end
      end
      ST_LOAD:     state_next = ST_OUT;
      ST_VEC_INIT: state_next = status.at_dest ? ST_TURN : ST_VEC_ITER;
      ST_VEC_ITER: if (status.iter_last) state_next = ST_TURN;
      ST_TURN:     state_next = ST_ROT_INIT;
      ST_ROT_INIT: state_next = ST_ROT_MUL;
      ST_ROT_MUL:  state_next = ST_ROT_ITER;
      ST_ROT_ITER: if (status.iter_last) state_next = ST_FINISH;
      ST_FINISH:   state_next = ST_OUT;
      ST_OUT:      if (!out_stall) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    in_stall = (state != ST_IDLE);
    out_valid = (state == ST_OUT);
    ctl.load = (state == ST_IDLE) && in_valid && (in_cmd == CMD_LOAD);
    ctl.vec_init = (state == ST_VEC_INIT);
    ctl.vec_iter = (state == ST_VEC_ITER);
    ctl.turn = (state == ST_TURN);
    ctl.rot_init = (state == ST_ROT_INIT);
    ctl.rot_mul = (state == ST_ROT_MUL);
    ctl.rot_iter = (state == ST_ROT_ITER);
    ctl.finish = (state == ST_FINISH);
  end

endmodule

// ===== sv/wpg_dp.sv =====
// ----------------------------------------------------------------------------
// wpg_dp
// Datapath: state registers and one shared CORDIC for bearing and motion.
// ----------------------------------------------------------------------------
module wpg_dp
  import wpg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  wpg_in_t     in_data,
  input  wpg_cmd_t    ctl,
  input  logic [1:0]  mode,
  input  logic [15:0] step_distance,
  input  logic [14:0] turn_step,
  input  logic [23:0] orbit_radius,
  input  logic signed [31:0] dest_x,
  input  logic signed [31:0] dest_y,
  output wpg_status_t status,
  output wpg_out_t    out_data
);

  logic signed [31:0] cur_x, cur_y;
  logic [15:0] cur_heading;
  // 33-bit deltas scaled by 2^16 plus CORDIC growth
  logic signed [51:0] cx, cy;
  logic signed [32:0] cz;
  logic [IterW-1:0] iter;
  logic [23:0] mag;
  logic [15:0] want;

  logic signed [32:0] ddx, ddy;
  logic signed [51:0] sx, sy;
  logic [31:0] at;
  logic [4:0] iter5;
  logic orbit;

  assign orbit = (mode == MODE_ORBIT);
  assign ddx = 33'(dest_x) - 33'(cur_x);
  assign ddy = 33'(dest_y) - 33'(cur_y);
  assign status.at_dest = (ddx == '0) && (ddy == '0);
  assign status.iter_last = (iter == IterW'(CORDIC_STEPS - 1));
  assign iter5 = 5'(iter);
  assign at = atan_lut(iter5);
  assign sx = cx >>> iter;
  assign sy = cy >>> iter;

  // turn toward bearing
  logic [15:0] dh;
  logic signed [16:0] d;
  logic [15:0] ad;
  logic [15:0] turn_hd;
  always_comb begin
    dh = want - cur_heading;
    d = {1'b0, dh};
    if (dh > 16'd32768) d = {1'b1, dh};
    if (dh == 16'd32768 && want < cur_heading) d = -17'sd32768;
    ad = d[16] ? 16'(-d) : 16'(d);
    if (ad > {1'b0, turn_step}) begin
      turn_hd = d[16] ? cur_heading - {1'b0, turn_step}
                      : cur_heading + {1'b0, turn_step};
    end else begin
      turn_hd = want;
    end
  end

  // rounded offsets and saturated sums
  logic signed [35:0] ox, oy;
  logic signed [36:0] nx, ny;
  logic signed [31:0] bx, by;
  assign ox = 36'((cx + 52'sd32768) >>> 16);
  assign oy = 36'((cy + 52'sd32768) >>> 16);
  assign bx = orbit ? dest_x : cur_x;
  assign by = orbit ? dest_y : cur_y;
  assign nx = 37'(bx) + 37'(ox);
  assign ny = 37'(by) + 37'(oy);

  function automatic logic signed [31:0] sat(input logic signed [36:0] v);
    if (v > 37'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -37'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic [31:0] ra;
  assign ra = {cur_heading, 16'h0};

  // magnitude*K with 16 extra fraction bits; at most 24x32 bits
  logic [55:0] mag_k;
  logic signed [51:0] start_x;
  logic rot_flip;
  assign mag_k = 56'(mag) * 56'(K_Q32);
  assign start_x = 52'(mag_k >> 16);
  assign rot_flip = (ra >= 32'h40000000) && (ra < 32'hC0000000);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x <= '0;
      cur_y <= '0;
      cur_heading <= '0;
    end else begin
      if (ctl.load) begin
        cur_x <= in_data.load_x;
        cur_y <= in_data.load_y;
        cur_heading <= in_data.load_heading;
      end
      if (ctl.turn) cur_heading <= turn_hd;
      if (ctl.rot_init && orbit) cur_heading <= cur_heading + {1'b0, turn_step};
      if (ctl.finish) begin
        cur_x <= sat(nx);
        cur_y <= sat(ny);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.vec_init) begin
      iter <= '0;
      want <= '0;
      if (ddx < 0) begin
        cx <= -(52'(ddx) <<< 16);
        cy <= -(52'(ddy) <<< 16);
        cz <= 33'sh080000000;
      end else begin
        cx <= 52'(ddx) <<< 16;
        cy <= 52'(ddy) <<< 16;
        cz <= '0;
      end
    end
    if (ctl.vec_iter) begin
      iter <= iter + 1'b1;
      if (cy >= 0) begin
        cx <= cx + sy; cy <= cy - sx; cz <= cz + 33'(at);
      end else begin
        cx <= cx - sy; cy <= cy + sx; cz <= cz - 33'(at);
      end
      if (status.iter_last) want <= 16'((cy >= 0 ? cz + 33'(at) : cz - 33'(at))
                                        + 33'sh8000 >>> 16);
    end
    if (ctl.rot_init) begin
      mag <= orbit ? orbit_radius : 24'(step_distance);
    end
    if (ctl.rot_mul) begin
      iter <= '0;
      cx <= rot_flip ? -start_x : start_x;
      cy <= '0;
      if (rot_flip) begin
        cz <= 33'($signed(ra - 32'h80000000));
      end else begin
        cz <= 33'($signed(ra));
      end
    end
    if (ctl.rot_iter) begin
      iter <= iter + 1'b1;
      if (cz >= 0) begin
        cx <= cx - sy; cy <= cy + sx; cz <= cz - 33'(at);
      end else begin
        cx <= cx + sy; cy <= cy - sx; cz <= cz + 33'(at);
      end
    end
  end

  assign out_data.pos_x = cur_x;
  assign out_data.pos_y = cur_y;
  assign out_data.heading = cur_heading;

endmodule
